// ----- rtl/core/toroidal_life_generation_engine_defines.svh -----
// Assertion macros for the toroidal Life engine.
// Included by the top level; relies on signals named clk and rst in scope.
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define TLGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlge assertion failed");
`define TLGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlge assertion failed");
`else
`define TLGE_ASSERT_IMP(lbl, ante, cons)
`define TLGE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/tlge_pkg.sv -----
// Package of the toroidal Life engine: operation codes, control types and
// the rule constants. No dependencies.
`timescale 1ns / 1ps

package tlge_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_OR    = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_STEP = 1'b1
  } state_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

  localparam logic [1:0] BITS3_COUNT [8] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [3:0] BIRTH_TOTAL = 4'd3;
  localparam logic [3:0] KEEP_TOTAL  = 4'd4;

endpackage

// ----- rtl/core/tlge_cmd_if.sv -----
// Command channel of the toroidal Life engine: valid, ready and payload.
// No dependencies.
`timescale 1ns / 1ps

interface tlge_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  row_index;
  logic [31:0] row_data;

  modport source (output valid, operation, row_index, row_data, input ready);
  modport sink   (input valid, operation, row_index, row_data, output ready);
endinterface

// ----- rtl/core/tlge_rsp_if.sv -----
// Result channel of the toroidal Life engine: valid, ready and payload.
// No dependencies.
`timescale 1ns / 1ps

interface tlge_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_row_index;
  logic [31:0] out_row_data;
  logic        last;

  modport source (output valid, out_row_index, out_row_data, last, input ready);
  modport sink   (input valid, out_row_index, out_row_data, last, output ready);
endinterface

// ----- rtl/core/tlge_row_cell.sv -----
// One row cell of the grid chain: holds a row, loads it on a write and
// takes its neighbour's row on a shift. Depends on tlge_pkg.
`timescale 1ns / 1ps

module tlge_row_cell
  import tlge_pkg::*;
#(
  parameter int GRID_COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [GRID_COLS-1:0] write_data,
  input  logic [GRID_COLS-1:0] shift_in,
  output logic [GRID_COLS-1:0] row
);

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (ctrl.write) begin
      row <= write_data;
    end else if (ctrl.shift) begin
      row <= shift_in;
    end
  end

endmodule

// ----- rtl/core/tlge_rule.sv -----
// Life rule for one row: counts each 3x3 block over three rows with wrap
// and applies B3/S23. Depends on tlge_pkg.
`timescale 1ns / 1ps

module tlge_rule
  import tlge_pkg::*;
#(
  parameter int GRID_COLS = 32
) (
  input  logic [GRID_COLS-1:0] above,
  input  logic [GRID_COLS-1:0] mid,
  input  logic [GRID_COLS-1:0] below,
  output logic [GRID_COLS-1:0] next_row
);

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam int LEFT  = (c + 1) % GRID_COLS;
    localparam int RIGHT = (c + GRID_COLS - 1) % GRID_COLS;
    logic [3:0] total;

    always_comb begin
      total = 4'(BITS3_COUNT[{above[LEFT], above[c], above[RIGHT]}])
            + 4'(BITS3_COUNT[{mid[LEFT], mid[c], mid[RIGHT]}])
            + 4'(BITS3_COUNT[{below[LEFT], below[c], below[RIGHT]}]);
      next_row[c] = (total == BIRTH_TOTAL) || ((total == KEEP_TOTAL) && mid[c]);
    end
  end

endmodule

// ----- rtl/core/toroidal_life_generation_engine.sv -----
// Top level of the toroidal Life engine: chain of row cells, rule logic,
// sequencer and result register. Depends on tlge_pkg, the channel
// interfaces, tlge_row_cell, tlge_rule and the defines header.
//
// Use: commands arrive on cmd (operation, row_index, row_data) and results
// leave on rsp (out_row_index, out_row_data, last); a transfer happens when
// valid and ready are both high. Overwrite, OR and read each give one
// result with last set, registered in the cycle after the transfer; a new
// command may follow in the next cycle while the receiver keeps pace.
// A step gives GRID_ROWS results, row 0 first, one per cycle while the
// receiver keeps pace: the grid rows rotate through the chain of cells by
// one place per result while the rule logic forms the new row from the
// rows above, at and below the head of the chain. No command is taken
// while a step is under way.
// Reset clears every cell and drops any pending result. When the receiver
// stalls, the result register holds and the chain stops rotating until
// the pending result is taken.
`timescale 1ns / 1ps
`include "toroidal_life_generation_engine_defines.svh"

module toroidal_life_generation_engine
  import tlge_pkg::*;
#(
  parameter int GRID_ROWS = 24,
  parameter int GRID_COLS = 32
) (
  input logic       clk,
  input logic       rst,
  tlge_cmd_if.sink  cmd,
  tlge_rsp_if.source rsp
);

  localparam int DW = (GRID_COLS > 32) ? GRID_COLS : 32;
  localparam int CW = $clog2(GRID_ROWS);
  localparam logic [CW-1:0] LAST_ROW = CW'(GRID_ROWS - 1);

  state_t state;
  state_t state_next;
  logic [CW-1:0] count;
  logic [GRID_COLS-1:0] prev;
  logic [GRID_COLS-1:0] first;
  logic [GRID_COLS-1:0] rows [GRID_ROWS];
  cell_ctrl_t ctrl [GRID_ROWS];

  logic ov;
  logic [4:0] o_idx;
  logic [31:0] o_data;
  logic o_last;

  logic adv;
  logic cmd_xfer;
  op_t op;
  logic idx_ok;
  logic [GRID_COLS-1:0] in_data;
  logic [GRID_COLS-1:0] sel_row;
  logic [GRID_COLS-1:0] wr_data;
  logic [GRID_COLS-1:0] below;
  logic [GRID_COLS-1:0] new_row;
  logic step_adv;
  logic write_op;

  assign op       = op_t'(cmd.operation);
  assign adv      = !ov || rsp.ready;
  assign cmd_xfer = cmd.valid && cmd.ready;
  assign idx_ok   = 32'(cmd.row_index) < GRID_ROWS;
  assign in_data  = DW'(cmd.row_data) >> 0 == '0 ? '0 : GRID_COLS'(DW'(cmd.row_data));
  assign step_adv = (state == ST_STEP) && adv;
  assign write_op = cmd_xfer && idx_ok && ((op == OP_WRITE) || (op == OP_OR));

  always_comb begin
    sel_row = '0;
    for (int i = 0; i < GRID_ROWS; i++) begin
      if (32'(cmd.row_index) == i) begin
        sel_row = rows[i];
      end
    end
  end

  assign wr_data = (op == OP_OR) ? (sel_row | in_data) : in_data;
  assign below   = (count == LAST_ROW) ? first : rows[1];

  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
    logic [GRID_COLS-1:0] shift_in;

    if (i == GRID_ROWS - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_body
      assign shift_in = rows[i+1];
    end

    always_comb begin
      ctrl[i].shift = step_adv;
      ctrl[i].write = write_op && (32'(cmd.row_index) == i);
    end

    tlge_row_cell #(.GRID_COLS(GRID_COLS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[i]),
      .write_data (wr_data),
      .shift_in   (shift_in),
      .row        (rows[i])
    );
  end

  tlge_rule #(.GRID_COLS(GRID_COLS)) u_rule (
    .above    (prev),
    .mid      (rows[0]),
    .below    (below),
    .next_row (new_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer && (op == OP_STEP)) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (adv && (count == LAST_ROW)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: cmd.ready = adv;
      ST_STEP: cmd.ready = 1'b0;
      default: cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd_xfer) begin
        count <= '0;
      end else if (step_adv) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      prev  <= rows[GRID_ROWS-1];
      first <= rows[0];
    end else if (step_adv) begin
      prev <= rows[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (step_adv || (cmd_xfer && (op != OP_STEP))) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_adv) begin
      o_idx  <= 5'(count);
      o_data <= DW'(new_row) >> 0 == '0 ? '0 : 32'(DW'(new_row));
      o_last <= (count == LAST_ROW);
    end else if (cmd_xfer && (op != OP_STEP)) begin
      o_idx  <= cmd.row_index;
      o_data <= idx_ok ? 32'(DW'(((op == OP_READ) ? sel_row : wr_data))) : '0;
      o_last <= 1'b1;
    end
  end

  assign rsp.valid         = ov;
  assign rsp.out_row_index = o_idx;
  assign rsp.out_row_data  = o_data;
  assign rsp.last          = o_last;

  `TLGE_ASSERT_IMP(a_no_cmd_in_step, state == ST_STEP, !cmd.ready)
  `TLGE_ASSERT_NXT(a_step_ends, step_adv && (count == LAST_ROW), state == ST_IDLE)
  `TLGE_ASSERT_NXT(a_last_only_final, step_adv && (count != LAST_ROW), rsp.valid && !rsp.last)

endmodule
